[hw/rtl/rbm_pkg.sv]
// ----------------------------------------------------------------------------
// rbm_pkg: shared types, constants and arithmetic helpers
// Fixed-point format, blend mode codes and stage payload structs for the
// RGBA blend pipeline.
// ----------------------------------------------------------------------------
package rbm_pkg;

  // Number format: unsigned fixed point, ONE = 2^FRACTION_BITS means 1.0.
  localparam int FRACTION_BITS = 15;
  localparam int FW = 16;                      // external field width
  localparam int VW = FRACTION_BITS + 1;       // saturated channel value
  localparam int RW = FRACTION_BITS + 2;       // rounded result before saturation
  localparam int PW = 2 * FRACTION_BITS + 2;   // product and mix sum

  // Configuration port.
  localparam int CFG_AW = 1;
  localparam int CFG_DW = FW;
  localparam int MODE_W = 3;
  localparam logic [CFG_AW-1:0] CFG_IDX_MODE   = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_IDX_FACTOR = 1'b1;

  typedef logic [FW-1:0] field_t;
  typedef logic [VW-1:0] chan_t;
  typedef logic [RW-1:0] rnd_t;
  typedef logic [PW-1:0] prod_t;

  localparam chan_t ONE   = chan_t'(1) << FRACTION_BITS;
  localparam prod_t HALF  = prod_t'(1) << (FRACTION_BITS - 1);
  localparam rnd_t  ONE_R = rnd_t'(ONE);

  typedef enum logic [MODE_W-1:0] {
    MODE_COPY        = 3'd0,
    MODE_BLEND       = 3'd1,
    MODE_OVERLAY     = 3'd2,
    MODE_OPAQUE      = 3'd3,
    MODE_BLACK_GREEN = 3'd4,
    MODE_WHITE_GREEN = 3'd5
  } mode_t;

  typedef struct packed {
    field_t red;
    field_t green;
    field_t blue;
    field_t alpha;
  } raw_rgba_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
  } rgba_t;

  // Stage 1: saturated operands.
  typedef struct packed {
    rgba_t base;
    rgba_t top;
    chan_t factor;
    mode_t mode;
    logic  last;
  } s1_t;

  // Stage 2: scalar factors.
  typedef struct packed {
    rgba_t base;
    rgba_t top;
    chan_t factor;
    chan_t t_mix;
    chan_t k_prod;
    chan_t green_alpha;
    mode_t mode;
    logic  last;
  } s2_t;

  // Stage 3: unrounded product pairs, index 0..3 is red, green, blue, alpha.
  typedef struct packed {
    rgba_t              base;
    logic [3:0][PW-1:0] prod_base;
    logic [3:0][PW-1:0] prod_top;
    mode_t              mode;
    logic               last;
  } s3_t;

  // Clamp an input field to one.
  function automatic chan_t sat_field(input field_t v);
    chan_t res;
    res = (v > field_t'(ONE)) ? ONE : v[VW-1:0];
    return res;
  endfunction

  // Clamp a rounded result to one.
  function automatic chan_t sat_rnd(input rnd_t v);
    chan_t res;
    res = (v > ONE_R) ? ONE : v[VW-1:0];
    return res;
  endfunction

  // Round half up and drop the fraction bits.
  function automatic rnd_t fx_round(input prod_t v);
    prod_t sum;
    sum = v + HALF;
    return sum[PW-1:FRACTION_BITS];
  endfunction

  // Rounded product of two values in 0..ONE; the result stays within 0..ONE.
  function automatic chan_t fx_mul(input chan_t a, input chan_t b);
    rnd_t r;
    r = fx_round(prod_t'(a) * prod_t'(b));
    return r[VW-1:0];
  endfunction

  // Unused mode codes behave as copy.
  function automatic mode_t decode_mode(input logic [MODE_W-1:0] code);
    mode_t m;
    unique case (code)
      MODE_BLEND:       m = MODE_BLEND;
      MODE_OVERLAY:     m = MODE_OVERLAY;
      MODE_OPAQUE:      m = MODE_OPAQUE;
      MODE_BLACK_GREEN: m = MODE_BLACK_GREEN;
      MODE_WHITE_GREEN: m = MODE_WHITE_GREEN;
      default:          m = MODE_COPY;
    endcase
    return m;
  endfunction

endpackage

[hw/rtl/rbm_if.sv]
// ----------------------------------------------------------------------------
// rbm_in_if / rbm_out_if: pixel stream channels
// Valid/ready channels carrying one pixel pair in and one blended pixel out.
// ----------------------------------------------------------------------------
interface rbm_in_if
  import rbm_pkg::*;
  ();
  logic   valid;
  logic   ready;
  field_t base_red;
  field_t base_green;
  field_t base_blue;
  field_t base_alpha;
  field_t top_red;
  field_t top_green;
  field_t top_blue;
  field_t top_alpha;
  logic   last_in;

  modport source (
    output valid, base_red, base_green, base_blue, base_alpha,
           top_red, top_green, top_blue, top_alpha, last_in,
    input  ready
  );
  modport sink (
    input  valid, base_red, base_green, base_blue, base_alpha,
           top_red, top_green, top_blue, top_alpha, last_in,
    output ready
  );
endinterface

interface rbm_out_if
  import rbm_pkg::*;
  ();
  logic   valid;
  logic   ready;
  field_t out_red;
  field_t out_green;
  field_t out_blue;
  field_t out_alpha;
  logic   last_out;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha, last_out,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha, last_out,
    output ready
  );
endinterface

[hw/rtl/rbm_front.sv]
// ----------------------------------------------------------------------------
// rbm_front: operand capture and scalar factor stages
// Stage 1 clamps the operands and samples the mode; stage 2 forms the
// top-alpha mix factor, the alpha coverage product and the green-alpha term.
// ----------------------------------------------------------------------------
module rbm_front
  import rbm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  raw_rgba_t         in_base,
  input  raw_rgba_t         in_top,
  input  logic              in_last,
  input  logic [MODE_W-1:0] cfg_mode,
  input  field_t            cfg_factor,
  output logic              s2_valid,
  input  logic              s2_ready,
  output s2_t               s2_data
);

  logic  s1_valid_r, s1_valid_nxt;
  s1_t   s1_r, s1_nxt;
  logic  s2_valid_r, s2_valid_nxt;
  s2_t   s2_r, s2_nxt;
  logic  s1_en, s2_en;
  chan_t green_sel;

  // A stage loads when it is empty or its contents move on.
  assign s2_en    = !s2_valid_r || s2_ready;
  assign s1_en    = !s1_valid_r || s2_en;
  assign in_ready = s1_en;

  // Stage 1: clamp operands to one and decode the mode.
  always_comb begin
    s1_nxt.base.red   = sat_field(in_base.red);
    s1_nxt.base.green = sat_field(in_base.green);
    s1_nxt.base.blue  = sat_field(in_base.blue);
    s1_nxt.base.alpha = sat_field(in_base.alpha);
    s1_nxt.top.red    = sat_field(in_top.red);
    s1_nxt.top.green  = sat_field(in_top.green);
    s1_nxt.top.blue   = sat_field(in_top.blue);
    s1_nxt.top.alpha  = sat_field(in_top.alpha);
    s1_nxt.factor     = sat_field(cfg_factor);
    s1_nxt.mode       = decode_mode(cfg_mode);
    s1_nxt.last       = in_last;
    s1_valid_nxt      = s1_en ? in_valid : s1_valid_r;
  end

  // Stage 2: scalar products shared by the channel mixes and alpha rules.
  always_comb begin
    green_sel = (s1_r.mode == MODE_BLACK_GREEN) ? (ONE - s1_r.base.green)
                                                : s1_r.base.green;
    s2_nxt.base        = s1_r.base;
    s2_nxt.top         = s1_r.top;
    s2_nxt.factor      = s1_r.factor;
    s2_nxt.t_mix       = fx_mul(s1_r.top.alpha, s1_r.factor);
    s2_nxt.k_prod      = fx_mul(ONE - s1_r.top.alpha, s1_r.factor);
    s2_nxt.green_alpha = fx_mul(green_sel, s1_r.base.alpha);
    s2_nxt.mode        = s1_r.mode;
    s2_nxt.last        = s1_r.last;
    s2_valid_nxt       = s2_en ? s1_valid_r : s2_valid_r;
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_r <= s1_nxt;
    end
    if (s2_en) begin
      s2_r <= s2_nxt;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_data  = s2_r;

endmodule

[hw/rtl/rbm_mix.sv]
// ----------------------------------------------------------------------------
// rbm_mix: product stage
// Forms the two weighted products of every channel mix and the alpha
// product selected by the blend mode, all unrounded.
// ----------------------------------------------------------------------------
module rbm_mix
  import rbm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic s2_valid,
  output logic s2_ready,
  input  s2_t  s2_data,
  output logic s3_valid,
  input  logic s3_ready,
  output s3_t  s3_data
);

  logic  s3_valid_r, s3_valid_nxt;
  s3_t   s3_r, s3_nxt;
  logic  s3_en;
  chan_t weight;
  chan_t k_cov;
  chan_t alpha_a, alpha_b;

  assign s3_en    = !s3_valid_r || s3_ready;
  assign s2_ready = s3_en;

  // Colour weight is the blend factor in blend mode, else top alpha times it.
  assign weight = (s2_data.mode == MODE_BLEND) ? s2_data.factor : s2_data.t_mix;
  assign k_cov  = ONE - s2_data.k_prod;

  // Operands of the alpha product for the four coverage rules.
  always_comb begin
    unique case (s2_data.mode)
      MODE_OVERLAY: begin
        alpha_a = ONE - s2_data.base.alpha;
        alpha_b = s2_data.t_mix;
      end
      MODE_OPAQUE: begin
        alpha_a = s2_data.base.alpha;
        alpha_b = k_cov;
      end
      MODE_BLACK_GREEN, MODE_WHITE_GREEN: begin
        alpha_a = s2_data.green_alpha;
        alpha_b = k_cov;
      end
      default: begin
        alpha_a = '0;
        alpha_b = '0;
      end
    endcase
  end

  // Products: (ONE - w) * base and w * top for each colour channel, and for alpha in blend mode.
  always_comb begin
    s3_nxt.base         = s2_data.base;
    s3_nxt.mode         = s2_data.mode;
    s3_nxt.last         = s2_data.last;
    s3_nxt.prod_base[0] = prod_t'(ONE - weight) * prod_t'(s2_data.base.red);
    s3_nxt.prod_top[0]  = prod_t'(weight) * prod_t'(s2_data.top.red);
    s3_nxt.prod_base[1] = prod_t'(ONE - weight) * prod_t'(s2_data.base.green);
    s3_nxt.prod_top[1]  = prod_t'(weight) * prod_t'(s2_data.top.green);
    s3_nxt.prod_base[2] = prod_t'(ONE - weight) * prod_t'(s2_data.base.blue);
    s3_nxt.prod_top[2]  = prod_t'(weight) * prod_t'(s2_data.top.blue);
    if (s2_data.mode == MODE_BLEND) begin
      s3_nxt.prod_base[3] = prod_t'(ONE - weight) * prod_t'(s2_data.base.alpha);
      s3_nxt.prod_top[3]  = prod_t'(weight) * prod_t'(s2_data.top.alpha);
    end else begin
      s3_nxt.prod_base[3] = prod_t'(alpha_a) * prod_t'(alpha_b);
      s3_nxt.prod_top[3]  = '0;
    end
    s3_valid_nxt = s3_en ? s2_valid : s3_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s3_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_r <= s3_nxt;
    end
  end

  assign s3_valid = s3_valid_r;
  assign s3_data  = s3_r;

endmodule

[hw/rtl/rbm_resolve.sv]
// ----------------------------------------------------------------------------
// rbm_resolve: rounding, saturation and output register
// Rounds the product sums, applies the alpha rule of the mode, clamps to
// one and clears the colour of fully transparent results.
// ----------------------------------------------------------------------------
module rbm_resolve
  import rbm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  s3_valid,
  output logic  s3_ready,
  input  s3_t   s3_data,
  output logic  out_valid,
  input  logic  out_ready,
  output rgba_t out_pix,
  output logic  out_last
);

  logic  out_valid_r, out_valid_nxt;
  rgba_t pix_r, pix_nxt;
  logic  last_r;
  logic  out_en;
  rgba_t res;
  rnd_t  alpha_rnd;

  assign out_en   = !out_valid_r || out_ready;
  assign s3_ready = out_en;

  // Rounded channel values per mode.
  always_comb begin
    alpha_rnd = fx_round(s3_data.prod_base[3] + s3_data.prod_top[3]);
    unique case (s3_data.mode)
      MODE_COPY: begin
        res = s3_data.base;
      end
      MODE_OVERLAY: begin
        res.red   = sat_rnd(fx_round(s3_data.prod_base[0] + s3_data.prod_top[0]));
        res.green = sat_rnd(fx_round(s3_data.prod_base[1] + s3_data.prod_top[1]));
        res.blue  = sat_rnd(fx_round(s3_data.prod_base[2] + s3_data.prod_top[2]));
        res.alpha = sat_rnd(rnd_t'(s3_data.base.alpha) + alpha_rnd);
      end
      default: begin
        res.red   = sat_rnd(fx_round(s3_data.prod_base[0] + s3_data.prod_top[0]));
        res.green = sat_rnd(fx_round(s3_data.prod_base[1] + s3_data.prod_top[1]));
        res.blue  = sat_rnd(fx_round(s3_data.prod_base[2] + s3_data.prod_top[2]));
        res.alpha = sat_rnd(alpha_rnd);
      end
    endcase
  end

  // A transparent result carries no colour.
  always_comb begin
    pix_nxt = res;
    if (res.alpha == '0) begin
      pix_nxt.red   = '0;
      pix_nxt.green = '0;
      pix_nxt.blue  = '0;
    end
    out_valid_nxt = out_en ? s3_valid : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      pix_r  <= pix_nxt;
      last_r <= s3_data.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pix   = pix_r;
  assign out_last  = last_r;

endmodule

[hw/rtl/rgba_blend_modes.sv]
// ----------------------------------------------------------------------------
// rgba_blend_modes: RGBA blend pipeline, top level
// Blends a base pixel with a top pixel under one of six modes.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one base/top pixel pair per transaction, out_ch one blended
//   pixel per transaction, in the same order. Channels are UQ1.15; inputs
//   above one are clamped to one.
//   The configuration port writes blend_mode (index 0) and blend_factor
//   (index 1) with cfg_we; write it only while the pipeline is empty.
//   The value in force when a pixel enters is the one used for it.
// Timing:
//   Four register stages: operand clamp, scalar factors, channel products,
//   rounding/output register. A pixel passes them in that order and is
//   offered on out_ch from the output register. One pixel per cycle enters
//   and leaves in steady state while out_ch.ready stays high.
// Reset:
//   rst_n empties all stages, sets the mode to copy and the factor to one.
// Back pressure:
//   Each stage holds its pixel while the next one is full and stalled, so
//   empty stages still fill while out_ch waits; in_ch.ready drops only once
//   all four stages hold a pixel.
// ----------------------------------------------------------------------------
module rgba_blend_modes
  import rbm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  rbm_in_if.sink            in_ch,
  rbm_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  logic [MODE_W-1:0] mode_r, mode_nxt;
  field_t            factor_r, factor_nxt;
  raw_rgba_t         in_base, in_top;
  logic              s2_valid, s2_ready;
  s2_t               s2_data;
  logic              s3_valid, s3_ready;
  s3_t               s3_data;
  rgba_t             out_pix;

  // Configuration registers.
  always_comb begin
    mode_nxt   = mode_r;
    factor_nxt = factor_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_IDX_MODE:   mode_nxt   = cfg_wdata[MODE_W-1:0];
        CFG_IDX_FACTOR: factor_nxt = cfg_wdata;
        default:        mode_nxt   = mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_COPY;
      factor_r <= field_t'(ONE);
    end else begin
      mode_r   <= mode_nxt;
      factor_r <= factor_nxt;
    end
  end

  // Input payload grouping.
  assign in_base = '{red: in_ch.base_red, green: in_ch.base_green,
                     blue: in_ch.base_blue, alpha: in_ch.base_alpha};
  assign in_top  = '{red: in_ch.top_red, green: in_ch.top_green,
                     blue: in_ch.top_blue, alpha: in_ch.top_alpha};

  rbm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_base    (in_base),
    .in_top     (in_top),
    .in_last    (in_ch.last_in),
    .cfg_mode   (mode_r),
    .cfg_factor (factor_r),
    .s2_valid   (s2_valid),
    .s2_ready   (s2_ready),
    .s2_data    (s2_data)
  );

  rbm_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2_data  (s2_data),
    .s3_valid (s3_valid),
    .s3_ready (s3_ready),
    .s3_data  (s3_data)
  );

  rbm_resolve u_resolve (
    .clk       (clk),
    .rst_n     (rst_n),
    .s3_valid  (s3_valid),
    .s3_ready  (s3_ready),
    .s3_data   (s3_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_pix   (out_pix),
    .out_last  (out_ch.last_out)
  );

  assign out_ch.out_red   = field_t'(out_pix.red);
  assign out_ch.out_green = field_t'(out_pix.green);
  assign out_ch.out_blue  = field_t'(out_pix.blue);
  assign out_ch.out_alpha = field_t'(out_pix.alpha);

  // A transparent result never carries colour.
  a_zero_alpha_clears_rgb: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.out_alpha == '0) |->
      (out_ch.out_red == '0 && out_ch.out_green == '0 && out_ch.out_blue == '0))
    else $error("transparent result with nonzero colour");

  // Every result channel stays within 0..ONE.
  a_results_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |->
      (out_ch.out_red <= field_t'(ONE) && out_ch.out_green <= field_t'(ONE) &&
       out_ch.out_blue <= field_t'(ONE) && out_ch.out_alpha <= field_t'(ONE)))
    else $error("result channel above one");

  // The pipeline is empty in the cycle after reset.
  a_empty_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_ch.valid && !s2_valid && !s3_valid))
    else $error("pipeline not empty after reset");

  // Input is refused only when the downstream stages are all occupied.
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s2_valid && s3_valid && out_ch.valid && !out_ch.ready))
    else $error("input stalled with room in the pipeline");

endmodule
